>>> src/aped_pkg.sv
package aped_pkg;

	localparam int COORD_BITS    = 16;
	localparam int WIDE_BITS     = COORD_BITS + 2;
	localparam int RADIUS_BITS   = 15;
	localparam int RULE_BITS     = 6;
	localparam int OP_BITS       = 2;
	localparam int RULES_DEF     = 64;
	localparam int MAX_DIRTY_DEF = 16;

	localparam logic [OP_BITS-1:0] OP_BEGIN = 2'd0;
	localparam logic [OP_BITS-1:0] OP_ADD   = 2'd1;
	localparam logic [OP_BITS-1:0] OP_EVAL  = 2'd2;

	localparam logic PHASE_ENTER = 1'b0;
	localparam logic PHASE_EXIT  = 1'b1;

	typedef struct packed {
		logic [COORD_BITS-1:0] x0;
		logic [COORD_BITS-1:0] y0;
		logic [COORD_BITS-1:0] x1;
		logic [COORD_BITS-1:0] y1;
	} box_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] h;
		logic [COORD_BITS-1:0] w;
		logic [COORD_BITS-1:0] y;
		logic [COORD_BITS-1:0] x;
	} rect_t;

	function automatic logic signed [WIDE_BITS-1:0] sx(input logic [COORD_BITS-1:0] v);
		return {{(WIDE_BITS-COORD_BITS){v[COORD_BITS-1]}}, v};
	endfunction

endpackage

>>> src/aped_ram.sv
module aped_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// hold the last read word until the next read
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> src/aped_hit.sv
module aped_hit (
	input  aped_pkg::box_t  box,
	input  aped_pkg::rect_t rect,
	output logic            hit
);
	import aped_pkg::*;

	logic signed [WIDE_BITS-1:0] rx0, ry0, rw, rh, rx1, ry1;
	logic signed [WIDE_BITS-1:0] bx0, by0, bx1, by1;
	logic                        nonempty;

	assign rx0 = sx(rect.x);
	assign ry0 = sx(rect.y);
	assign rw  = sx(rect.w);
	assign rh  = sx(rect.h);
	// inclusive far edges of the rectangle
	assign rx1 = rx0 + rw - WIDE_BITS'(1);
	assign ry1 = ry0 + rh - WIDE_BITS'(1);

	assign bx0 = sx(box.x0);
	assign by0 = sx(box.y0);
	assign bx1 = sx(box.x1);
	assign by1 = sx(box.y1);

	assign nonempty = (rw > WIDE_BITS'(0)) && (rh > WIDE_BITS'(0));

	assign hit = nonempty && !(bx1 < rx0) && !(bx0 > rx1) && !(by1 < ry0) && !(by0 > ry1);

endmodule

>>> src/aabb_proximity_edge_detector.sv
// Proximity edge detector for axis-aligned boxes, one inside latch per rule.
// Input channel item_valid/item_stall carries one transaction per item:
// op 0 starts a frame and empties the dirty-rectangle list, op 1 appends a
// rectangle, op 2 evaluates a rule. Output channel event_valid/event_stall
// carries an enter or exit event when an evaluation of a present pair flips
// a rule's latch. Begin-frame and add-rectangle items leave the block idle.
// An evaluation goes to DECIDE with the dirty filter off, and through SCAN,
// TAIL and DECIDE with it on, SCAN walking the rectangle memory at one entry
// per cycle; the event appears in the cycle after the decision.
// After reset the latch memory is cleared one rule per cycle with item_stall
// high; counters and the event register clear at once.
// While the receiver stalls, the event register holds; further items that
// produce no event still flow, and an evaluation that must emit waits at its
// decision step until the event register frees.
module aabb_proximity_edge_detector #(
	parameter int RULES     = aped_pkg::RULES_DEF,
	parameter int MAX_DIRTY = aped_pkg::MAX_DIRTY_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   item_valid,
	output logic                                   item_stall,
	input  logic [aped_pkg::OP_BITS-1:0]           op,
	input  logic [aped_pkg::RULE_BITS-1:0]         rule_index,
	input  logic                                   both_present,
	input  logic [aped_pkg::RADIUS_BITS-1:0]       radius,
	input  logic signed [aped_pkg::COORD_BITS-1:0] self_min_x,
	input  logic signed [aped_pkg::COORD_BITS-1:0] self_min_y,
	input  logic signed [aped_pkg::COORD_BITS-1:0] self_max_x,
	input  logic signed [aped_pkg::COORD_BITS-1:0] self_max_y,
	input  logic signed [aped_pkg::COORD_BITS-1:0] other_min_x,
	input  logic signed [aped_pkg::COORD_BITS-1:0] other_min_y,
	input  logic signed [aped_pkg::COORD_BITS-1:0] other_max_x,
	input  logic signed [aped_pkg::COORD_BITS-1:0] other_max_y,
	output logic                                   event_valid,
	input  logic                                   event_stall,
	output logic [aped_pkg::RULE_BITS-1:0]         event_rule,
	output logic                                   event_phase
);
	import aped_pkg::*;

	localparam int LAW = (RULES > 1) ? $clog2(RULES) : 1;
	localparam int DAW = (MAX_DIRTY > 1) ? $clog2(MAX_DIRTY) : 1;
	localparam int CW  = $clog2(MAX_DIRTY + 1);

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_TAIL   = 3'd3;
	localparam logic [2:0] ST_DECIDE = 3'd4;

	logic [2:0]           state_q;
	logic [LAW-1:0]       clr_idx_q;
	logic [DAW-1:0]       scan_idx_q;
	logic [CW-1:0]        dcount_q;
	logic                 dovf_q;
	logic                 rd_vld_q;
	logic                 hit_q;
	logic [RULE_BITS-1:0] rule_q;
	logic [RADIUS_BITS-1:0] radius_q;
	box_t                 self_q;
	box_t                 other_q;
	logic                 event_valid_q;
	logic [RULE_BITS-1:0] event_rule_q;
	logic                 event_phase_q;

	logic                 acc;
	logic                 rule_ok;
	logic                 full;
	logic                 filter_on;
	logic [LAW-1:0]       rule_addr_in;

	logic                 lat_we, lat_re, lat_wdata, lat_rdata;
	logic [LAW-1:0]       lat_waddr;
	logic                 rect_we, rect_re;
	rect_t                rect_wdata, rect_rdata;

	logic                 hit_self, hit_other;
	logic                 scan_last;
	logic signed [WIDE_BITS-1:0] rad_w, sx0, sy0, sx1, sy1;
	logic                 now_inside;
	logic                 change;
	logic                 out_free;
	logic                 ev_load;

	assign acc          = item_valid && !item_stall;
	assign item_stall   = (state_q != ST_IDLE);
	assign rule_ok      = 32'(rule_index) < 32'(RULES);
	assign full         = (dcount_q == CW'(MAX_DIRTY));
	assign filter_on    = (dcount_q != CW'(0)) && !dovf_q;
	assign rule_addr_in = LAW'(rule_index);
	assign scan_last    = (CW'(scan_idx_q) + CW'(1)) == dcount_q;

	assign rect_wdata.x = self_min_x;
	assign rect_wdata.y = self_min_y;
	assign rect_wdata.w = self_max_x;
	assign rect_wdata.h = self_max_y;
	assign rect_re      = (state_q == ST_SCAN);

	// widen the self box by the radius, then test inclusive overlap
	assign rad_w = {{(WIDE_BITS-RADIUS_BITS){1'b0}}, radius_q};
	assign sx0   = sx(self_q.x0) - rad_w;
	assign sy0   = sx(self_q.y0) - rad_w;
	assign sx1   = sx(self_q.x1) + rad_w;
	assign sy1   = sx(self_q.y1) + rad_w;
	assign now_inside = (sx0 <= sx(other_q.x1)) && (sx(other_q.x0) <= sx1) &&
		(sy0 <= sx(other_q.y1)) && (sx(other_q.y0) <= sy1);
	assign change   = now_inside != lat_rdata;
	assign out_free = !event_valid_q || !event_stall;
	assign ev_load  = (state_q == ST_DECIDE) && hit_q && change && out_free;

	always_comb begin
		lat_we    = 1'b0;
		lat_waddr = rule_addr_in;
		lat_wdata = 1'b0;
		lat_re    = 1'b0;
		rect_we   = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				lat_we    = 1'b1;
				lat_waddr = clr_idx_q;
			end
			ST_IDLE: begin
				if (acc && op == OP_EVAL && rule_ok) begin
					// missing entity drops the latch without an event
					lat_we = !both_present;
					lat_re = both_present;
				end
				if (acc && op == OP_ADD && !full) begin
					rect_we = 1'b1;
				end
			end
			ST_DECIDE: begin
				lat_we    = ev_load;
				lat_waddr = LAW'(rule_q);
				lat_wdata = now_inside;
			end
			default: begin
			end
		endcase
	end

	aped_ram #(
		.WIDTH(1),
		.DEPTH(RULES)
	) u_latch_ram (
		.clk  (clk),
		.we   (lat_we),
		.waddr(lat_waddr),
		.wdata(lat_wdata),
		.re   (lat_re),
		.raddr(rule_addr_in),
		.rdata(lat_rdata)
	);

	aped_ram #(
		.WIDTH($bits(rect_t)),
		.DEPTH(MAX_DIRTY)
	) u_rect_ram (
		.clk  (clk),
		.we   (rect_we),
		.waddr(dcount_q[DAW-1:0]),
		.wdata(rect_wdata),
		.re   (rect_re),
		.raddr(scan_idx_q),
		.rdata(rect_rdata)
	);

	aped_hit u_hit_self (
		.box (self_q),
		.rect(rect_rdata),
		.hit (hit_self)
	);

	aped_hit u_hit_other (
		.box (other_q),
		.rect(rect_rdata),
		.hit (hit_other)
	);

	always_ff @(posedge clk) begin
		if (acc && op == OP_EVAL) begin
			rule_q   <= rule_index;
			radius_q <= radius;
			self_q   <= {self_min_x, self_min_y, self_max_x, self_max_y};
			other_q  <= {other_min_x, other_min_y, other_max_x, other_max_y};
		end
		if (ev_load) begin
			event_rule_q  <= rule_q;
			event_phase_q <= now_inside ? PHASE_ENTER : PHASE_EXIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_idx_q     <= '0;
			scan_idx_q    <= '0;
			dcount_q      <= '0;
			dovf_q        <= 1'b0;
			rd_vld_q      <= 1'b0;
			hit_q         <= 1'b0;
			event_valid_q <= 1'b0;
		end else begin
			rd_vld_q <= rect_re;
			if (rd_vld_q && (hit_self || hit_other)) begin
				hit_q <= 1'b1;
			end
			if (ev_load) begin
				event_valid_q <= 1'b1;
			end else if (event_valid_q && !event_stall) begin
				event_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + LAW'(1);
					if (clr_idx_q == LAW'(RULES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (acc) begin
						case (op)
							OP_BEGIN: begin
								dcount_q <= '0;
								dovf_q   <= 1'b0;
							end
							OP_ADD: begin
								if (full) begin
									dovf_q <= 1'b1;
								end else begin
									dcount_q <= dcount_q + CW'(1);
								end
							end
							OP_EVAL: begin
								if (rule_ok && both_present) begin
									// with the filter off every item counts as touched
									hit_q      <= !filter_on;
									scan_idx_q <= '0;
									state_q    <= filter_on ? ST_SCAN : ST_DECIDE;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					scan_idx_q <= scan_idx_q + DAW'(1);
					if (scan_last) begin
						state_q <= ST_TAIL;
					end
				end
				ST_TAIL: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					// drop skipped or unchanged items; hold while the event register is busy
					if (!hit_q || !change || out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign event_valid = event_valid_q;
	assign event_rule  = event_rule_q;
	assign event_phase = event_phase_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dcount_q <= CW'(MAX_DIRTY))
		else $error("dirty count beyond list size");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		dovf_q |-> full)
		else $error("overflow set with list not full");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> CW'(scan_idx_q) < dcount_q)
		else $error("scan reads past the stored rectangles");

	a_latch_event: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECIDE && lat_we) |=> (event_valid_q && event_phase_q == !$past(lat_wdata)))
		else $error("latch update without matching event");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_TAIL || state_q == ST_CLEAR) |-> !acc)
		else $error("item accepted while busy");
`endif

endmodule

>>> bench/tb.sv
module tb;
	import aped_pkg::*;

	localparam int CLK_HALF     = 4;
	localparam int WORK_ITEMS   = 1600;
	localparam int QUIET_ITEMS  = 150;
	localparam int DRAIN_CYCLES = MAX_DIRTY_DEF + 8;
	localparam int CYCLE_LIMIT  = 300000;

	localparam logic [OP_BITS-1:0] OP_SPARE = 2'd3;

	typedef struct packed {
		logic [OP_BITS-1:0]            op;
		logic [RULE_BITS-1:0]          rule_index;
		logic                          both_present;
		logic [RADIUS_BITS-1:0]        radius;
		logic signed [COORD_BITS-1:0]  self_min_x;
		logic signed [COORD_BITS-1:0]  self_min_y;
		logic signed [COORD_BITS-1:0]  self_max_x;
		logic signed [COORD_BITS-1:0]  self_max_y;
		logic signed [COORD_BITS-1:0]  other_min_x;
		logic signed [COORD_BITS-1:0]  other_min_y;
		logic signed [COORD_BITS-1:0]  other_max_x;
		logic signed [COORD_BITS-1:0]  other_max_y;
	} item_t;

	typedef struct packed {
		logic [RULE_BITS-1:0] rule;
		logic                 phase;
	} edge_event_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         item_valid = 1'b0;
	logic                         item_stall;
	logic [OP_BITS-1:0]           op = '0;
	logic [RULE_BITS-1:0]         rule_index = '0;
	logic                         both_present = 1'b0;
	logic [RADIUS_BITS-1:0]       radius = '0;
	logic signed [COORD_BITS-1:0] self_min_x = '0;
	logic signed [COORD_BITS-1:0] self_min_y = '0;
	logic signed [COORD_BITS-1:0] self_max_x = '0;
	logic signed [COORD_BITS-1:0] self_max_y = '0;
	logic signed [COORD_BITS-1:0] other_min_x = '0;
	logic signed [COORD_BITS-1:0] other_min_y = '0;
	logic signed [COORD_BITS-1:0] other_max_x = '0;
	logic signed [COORD_BITS-1:0] other_max_y = '0;
	logic                         event_valid;
	logic                         event_stall = 1'b0;
	logic [RULE_BITS-1:0]         event_rule;
	logic                         event_phase;

	aabb_proximity_edge_detector uut (.*);

	always #(CLK_HALF) clk = ~clk;

	item_t       pending_items[$];
	edge_event_t pending_events[$];
	item_t       cur_item;
	logic        item_taken = 1'b0;
	bit          run_started = 1'b0;
	int          work_items = 0;
	int          gap_left = 0;
	int          send_calm = 0;
	int          stall_left = 0;
	int          recv_calm = 0;
	int          cycle_count = 0;
	int          mismatches = 0;
	int          enter_count = 0;
	int          exit_count = 0;
	int          filtered_count = 0;
	int          overflow_count = 0;

	// predictor state
	bit     rule_inside[RULES_DEF];
	longint dirty_x[MAX_DIRTY_DEF];
	longint dirty_y[MAX_DIRTY_DEF];
	longint dirty_w[MAX_DIRTY_DEF];
	longint dirty_h[MAX_DIRTY_DEF];
	int     dirty_count = 0;
	bit     dirty_full = 1'b0;

	function automatic bit touches_dirty(input longint x0, input longint y0,
			input longint x1, input longint y1);
		for (int i = 0; i < dirty_count; i++) begin
			if (dirty_w[i] > 0 && dirty_h[i] > 0 &&
					x1 >= dirty_x[i] && x0 <= dirty_x[i] + dirty_w[i] - 1 &&
					y1 >= dirty_y[i] && y0 <= dirty_y[i] + dirty_h[i] - 1)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic detect_proximity_edge(input item_t it);
		longint      sx0, sy0, sx1, sy1, ox0, oy0, ox1, oy1, rad;
		bit          now_in;
		edge_event_t ev;
		sx0 = longint'($signed(it.self_min_x));
		sy0 = longint'($signed(it.self_min_y));
		sx1 = longint'($signed(it.self_max_x));
		sy1 = longint'($signed(it.self_max_y));
		ox0 = longint'($signed(it.other_min_x));
		oy0 = longint'($signed(it.other_min_y));
		ox1 = longint'($signed(it.other_max_x));
		oy1 = longint'($signed(it.other_max_y));
		rad = longint'(it.radius);
		case (it.op)
			OP_BEGIN: begin
				dirty_count = 0;
				dirty_full = 1'b0;
			end
			OP_ADD: begin
				if (dirty_count < MAX_DIRTY_DEF) begin
					dirty_x[dirty_count] = sx0;
					dirty_y[dirty_count] = sy0;
					dirty_w[dirty_count] = sx1;
					dirty_h[dirty_count] = sy1;
					dirty_count++;
				end else begin
					if (!dirty_full)
						overflow_count++;
					dirty_full = 1'b1;
				end
			end
			OP_EVAL: begin
				if (!it.both_present) begin
					rule_inside[it.rule_index] = 1'b0;
				end else if (dirty_count > 0 && !dirty_full &&
						!touches_dirty(sx0, sy0, sx1, sy1) &&
						!touches_dirty(ox0, oy0, ox1, oy1)) begin
					filtered_count++;
				end else begin
					now_in = (sx0 - rad <= ox1) && (ox0 <= sx1 + rad) &&
						(sy0 - rad <= oy1) && (oy0 <= sy1 + rad);
					if (now_in != rule_inside[it.rule_index]) begin
						rule_inside[it.rule_index] = now_in;
						ev.rule = it.rule_index;
						ev.phase = now_in ? PHASE_ENTER : PHASE_EXIT;
						pending_events.push_back(ev);
						if (now_in)
							enter_count++;
						else
							exit_count++;
					end
				end
			end
			default: ;
		endcase
	endtask

	function automatic item_t random_item();
		item_t it;
		it.op = OP_BITS'($urandom);
		it.rule_index = RULE_BITS'($urandom);
		it.both_present = 1'($urandom);
		it.radius = RADIUS_BITS'($urandom);
		it.self_min_x = COORD_BITS'($urandom);
		it.self_min_y = COORD_BITS'($urandom);
		it.self_max_x = COORD_BITS'($urandom);
		it.self_max_y = COORD_BITS'($urandom);
		it.other_min_x = COORD_BITS'($urandom);
		it.other_min_y = COORD_BITS'($urandom);
		it.other_max_x = COORD_BITS'($urandom);
		it.other_max_y = COORD_BITS'($urandom);
		return it;
	endfunction

	function automatic logic signed [COORD_BITS-1:0] pick_coord(input int lo, input int hi);
		int v;
		v = lo + int'($urandom_range(hi - lo, 0));
		return COORD_BITS'(v);
	endfunction

	function automatic void queue_item(input item_t it);
		pending_items.push_back(it);
		if (it.op != OP_SPARE)
			work_items++;
	endfunction

	function automatic void queue_op(input logic [OP_BITS-1:0] kind);
		item_t it;
		it = random_item();
		it.op = kind;
		queue_item(it);
	endfunction

	function automatic void queue_rect(input int x, input int y, input int w, input int h);
		item_t it;
		it = random_item();
		it.op = OP_ADD;
		it.self_min_x = COORD_BITS'(x);
		it.self_min_y = COORD_BITS'(y);
		it.self_max_x = COORD_BITS'(w);
		it.self_max_y = COORD_BITS'(h);
		queue_item(it);
	endfunction

	function automatic void queue_eval(input int rule, input bit present, input int rad,
			input int sx0, input int sy0, input int sx1, input int sy1,
			input int ox0, input int oy0, input int ox1, input int oy1);
		item_t it;
		it.op = OP_EVAL;
		it.rule_index = RULE_BITS'(rule);
		it.both_present = present;
		it.radius = RADIUS_BITS'(rad);
		it.self_min_x = COORD_BITS'(sx0);
		it.self_min_y = COORD_BITS'(sy0);
		it.self_max_x = COORD_BITS'(sx1);
		it.self_max_y = COORD_BITS'(sy1);
		it.other_min_x = COORD_BITS'(ox0);
		it.other_min_y = COORD_BITS'(oy0);
		it.other_max_x = COORD_BITS'(ox1);
		it.other_max_y = COORD_BITS'(oy1);
		queue_item(it);
	endfunction

	function automatic void queue_random_frame();
		int nrect, neval, cx, cy, sz, rad, rule;
		if ($urandom_range(9, 0) != 0)
			queue_op(OP_BEGIN);
		// mostly short lists, sometimes enough to overflow
		nrect = ($urandom_range(4, 0) == 0) ? $urandom_range(18, 14) : $urandom_range(4, 0);
		for (int i = 0; i < nrect; i++)
			queue_rect(pick_coord(-150, 150), pick_coord(-150, 150),
				pick_coord(-3, 80), pick_coord(-3, 80));
		neval = $urandom_range(8, 2);
		for (int i = 0; i < neval; i++) begin
			rule = ($urandom_range(3, 0) != 0) ? $urandom_range(7, 0) : $urandom_range(63, 0);
			rad = ($urandom_range(9, 0) != 0) ? $urandom_range(40, 0) : $urandom_range(32767, 0);
			cx = pick_coord(-200, 200);
			cy = pick_coord(-200, 200);
			sz = $urandom_range(60, 0);
			if ($urandom_range(19, 0) == 0)
				queue_eval(rule, 1'b1, rad, cx + sz, cy, cx, cy + sz,
					pick_coord(-200, 200), pick_coord(-200, 200),
					pick_coord(-200, 200), pick_coord(-200, 200));
			else
				queue_eval(rule, $urandom_range(15, 0) != 0, rad, cx, cy,
					cx + sz, cy + $urandom_range(60, 0),
					cx + pick_coord(-100, 100), cy + pick_coord(-100, 100),
					cx + sz + pick_coord(-20, 100), cy + sz + pick_coord(-20, 100));
		end
		if ($urandom_range(49, 0) == 0)
			queue_op(OP_SPARE);
	endfunction

	// driver: present the next transaction at the falling edge
	always @(negedge clk) begin
		if (send_calm > 0)
			send_calm--;
		else if ($urandom_range(99, 0) == 0)
			send_calm = $urandom_range(80, 20);
		if (item_valid && !item_taken) begin
			// hold until accepted
		end else if (gap_left > 0) begin
			gap_left--;
			item_valid <= 1'b0;
		end else if (run_started && pending_items.size() > 0) begin
			if (pending_items.size() > QUIET_ITEMS && send_calm == 0 &&
					$urandom_range(4, 0) == 0) begin
				gap_left = $urandom_range(2, 0);
				item_valid <= 1'b0;
			end else begin
				cur_item = pending_items.pop_front();
				op <= cur_item.op;
				rule_index <= cur_item.rule_index;
				both_present <= cur_item.both_present;
				radius <= cur_item.radius;
				self_min_x <= cur_item.self_min_x;
				self_min_y <= cur_item.self_min_y;
				self_max_x <= cur_item.self_max_x;
				self_max_y <= cur_item.self_max_y;
				other_min_x <= cur_item.other_min_x;
				other_min_y <= cur_item.other_min_y;
				other_max_x <= cur_item.other_max_x;
				other_max_y <= cur_item.other_max_y;
				item_valid <= 1'b1;
			end
		end else begin
			item_valid <= 1'b0;
		end
	end

	// receiver back-pressure in short bursts
	always @(negedge clk) begin
		if (recv_calm > 0)
			recv_calm--;
		else if ($urandom_range(99, 0) == 0)
			recv_calm = $urandom_range(80, 20);
		if (stall_left > 0) begin
			stall_left--;
			event_stall <= 1'b1;
		end else if (pending_items.size() > QUIET_ITEMS && recv_calm == 0 &&
				$urandom_range(4, 0) == 0) begin
			stall_left = $urandom_range(2, 0);
			event_stall <= 1'b1;
		end else begin
			event_stall <= 1'b0;
		end
	end

	// monitor: predict on accepted items, check accepted events
	always @(posedge clk) begin
		edge_event_t want;
		if (arst_n) begin
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end else begin
				item_taken <= item_valid && !item_stall;
				if (item_valid && !item_stall)
					detect_proximity_edge(cur_item);
				if (event_valid && !event_stall) begin
					if (pending_events.size() == 0) begin
						$error("unexpected event: rule %0d phase %0d", event_rule, event_phase);
						mismatches++;
					end else begin
						want = pending_events.pop_front();
						if (event_rule !== want.rule) begin
							$error("event_rule: expected %0d, actual %0d", want.rule, event_rule);
							mismatches++;
						end
						if (event_phase !== want.phase) begin
							$error("event_phase: expected %0d, actual %0d",
								want.phase, event_phase);
							mismatches++;
						end
					end
				end
			end
		end
	end

	initial begin
		for (int i = 0; i < RULES_DEF; i++)
			rule_inside[i] = 1'b0;

		// edge sequence on one rule, inclusive touch, missing entity
		queue_op(OP_BEGIN);
		queue_eval(0, 1'b1, 0, 0, 0, 10, 10, 5, 5, 20, 20);
		queue_eval(0, 1'b1, 0, 0, 0, 10, 10, 5, 5, 20, 20);
		queue_eval(0, 1'b1, 0, 0, 0, 10, 10, 11, 0, 20, 10);
		queue_eval(0, 1'b1, 1, 0, 0, 10, 10, 11, 0, 20, 10);
		queue_eval(0, 1'b0, 1, 0, 0, 10, 10, 11, 0, 20, 10);
		queue_eval(0, 1'b1, 1, 0, 0, 10, 10, 11, 0, 20, 10);
		// coordinate and radius extremes; widened edges leave the 16-bit range
		queue_eval(63, 1'b1, 32767, -32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767);
		queue_eval(63, 1'b1, 32767, 32767, 32767, 32767, 32767,
			-32768, -32768, -32768, -32768);
		queue_eval(62, 1'b1, 32767, 32767, 32767, 32767, 32767, 0, 0, 0, 0);
		// inverted boxes
		queue_eval(5, 1'b1, 0, 0, 0, 10, 10, 50, 50, -50, -50);
		queue_eval(5, 1'b1, 20, 10, 10, 0, 0, 30, 30, 30, 30);
		queue_op(OP_SPARE);
		// dirty filter with empty rectangles mixed in
		queue_op(OP_BEGIN);
		queue_rect(100, 100, 10, 10);
		queue_rect(0, 0, 0, 5);
		queue_rect(0, 0, 5, -3);
		queue_eval(7, 1'b1, 0, 0, 0, 4, 4, 2, 2, 3, 3);
		queue_eval(7, 1'b1, 200, 0, 0, 4, 4, 109, 109, 120, 120);
		queue_eval(7, 1'b1, 0, 0, 0, 4, 4, 110, 110, 120, 120);
		queue_eval(7, 1'b1, 0, 95, 95, 100, 100, 200, 200, 200, 200);
		queue_op(OP_BEGIN);
		queue_eval(7, 1'b1, 0, 0, 0, 4, 4, 2, 2, 3, 3);

		while (work_items < WORK_ITEMS) begin
			if ($urandom_range(99, 0) < 8)
				queue_item(random_item());
			else
				queue_random_frame();
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		run_started = 1'b1;

		while (pending_items.size() != 0 || item_valid || pending_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d transactions in %0d cycles: %0d enter and %0d exit events,",
			work_items, cycle_count, enter_count, exit_count);
		$display("%0d evaluations dropped by the dirty filter, %0d list overflows",
			filtered_count, overflow_count);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
